// ----- src/bbce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbce_pkg
// shared types and constants for the bezier / uniform b-spline curve evaluator
// ----------------------------------------------------------------------------
package bbce_pkg;

    localparam int MAX_POINTS = 16;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int COORD_W    = 32;
    localparam int WGT_W      = 31;
    localparam int MUL_W      = 34;
    localparam int ACC_W      = 64;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [WGT_W-1:0] ONE_Q30 = WGT_W'(1 << 30);
    localparam logic [MUL_W-1:0] RECIP3 = MUL_W'(34'h0AAAAAAAB);

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_EVAL   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BEZIER = 2'd0,
        KIND_CUBIC  = 2'd1,
        KIND_QUAD   = 2'd2,
        KIND_SPARE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BZ_A,
        S_BZ_B,
        S_BZ_C,
        S_SP_F2,
        S_SP_F3,
        S_SP_G2,
        S_SP_G3,
        S_SP_DIV1,
        S_SP_DIV2,
        S_AC_CHK,
        S_AC_MUL,
        S_AC_ADD,
        S_FIN
    } t_state;

endpackage

// ----- src/bezier_bspline_curve_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_bspline_curve_eval
// control point store with bezier and uniform b-spline evaluation
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// command   in         start & !busy           i_mode, i_point_*, i_curve_param
// result    out        o_done (one cycle)      o_curve_*, o_point_count, o_store_full
// config    in         i_cfg_we                i_cfg_wdata (curve kind)
//
// clear, append, the no-op mode and an empty-store evaluate return in the cycle after the transaction.
// bezier over n points: (n-1)(n+2)/2 recurrence steps (S_BZ_A, S_BZ_B, S_BZ_C), then
// a multiply-accumulate per coordinate of each point, then S_FIN; the b-splines first
// form their basis weights, and skip each term whose point lies outside the store.
// all arithmetic runs through the one shared 34x34 multiplier under the sequencer.
// reset empties the store and sets the kind to bezier; the receiver cannot stall.
// ----------------------------------------------------------------------------
module bezier_bspline_curve_eval
    import bbce_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_mode,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic [20:0]               i_curve_param,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_wdata,
    output logic                      o_done,
    output logic signed [COORD_W-1:0] o_curve_x,
    output logic signed [COORD_W-1:0] o_curve_y,
    output logic signed [COORD_W-1:0] o_curve_z,
    output logic [CNT_W-1:0]          o_point_count,
    output logic                      o_store_full
);

    t_state r_state, n_state;
    t_kind  r_kind;

    logic [COORD_W-1:0] r_cx [MAX_POINTS];
    logic [COORD_W-1:0] r_cy [MAX_POINTS];
    logic [COORD_W-1:0] r_cz [MAX_POINTS];
    logic [CNT_W-1:0]   r_count;

    logic [WGT_W-1:0]   r_w [MAX_POINTS];
    logic [16:0]        r_t, r_s;
    logic [15:0]        r_f;
    logic [16:0]        r_g;
    logic [31:0]        r_f2;
    logic [47:0]        r_f3;
    logic [32:0]        r_g2;
    logic               r_cubic;
    logic [1:0]         r_r;
    logic [IDX_W-1:0]   r_lvl, r_i, r_k;
    logic [CNT_W-1:0]   r_n;
    logic signed [6:0]  r_base;
    logic [IDX_W-1:0]   r_idx;
    logic [1:0]         r_j;
    logic [47:0]        r_sum;
    logic signed [67:0] r_prod;
    logic signed [ACC_W-1:0] r_acc [3];

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [67:0]      w_prod;
    logic [IDX_W-1:0]        w_addr;
    logic [WGT_W-1:0]        w_rd;
    logic [COORD_W-1:0]      c_rd;
    logic [55:0]             num;
    logic [55:0]             num_rnd;
    logic signed [6:0]       idx;
    logic                    idx_ok;
    logic                    k_last;
    logic [48:0]             bz_new;
    logic signed [COORD_W-1:0] fin [3];
    logic signed [ACC_W-1:0]   fin_x [3];
    logic signed [33:0]        fin_q [3];
    logic [1:0]                deg;

    assign busy   = (r_state != S_IDLE);
    assign deg    = r_cubic ? 2'd3 : 2'd2;
    assign idx    = r_base + $signed({3'b000, r_k});
    assign idx_ok = (idx >= 7'sd0) && (idx < $signed({2'b00, r_count}));
    assign k_last = ({1'b0, r_k} == (r_n - CNT_W'(1)));
    assign w_rd   = r_w[w_addr];
    assign bz_new = {1'b0, r_sum} + {1'b0, r_prod[47:0]} + 49'd32768;
    assign w_prod = mul_a * mul_b;
    assign num_rnd = num + (r_cubic ? 56'd786432 : 56'd4);

    always_comb begin
        unique case (r_state)
            S_BZ_A:  w_addr = r_i;
            S_BZ_B:  w_addr = r_i - IDX_W'(1);
            default: w_addr = r_k;
        endcase
    end

    always_comb begin
        case (r_j)
            2'd0:    c_rd = r_cx[r_idx];
            2'd1:    c_rd = r_cy[r_idx];
            default: c_rd = r_cz[r_idx];
        endcase
    end

    always_comb begin
        if (r_cubic) begin
            case (r_r)
                2'd0: num = 56'(r_prod[48:0]);
                2'd1: num = 56'(r_f3) + 56'({r_f3, 1'b0}) - 56'({r_f2, 17'd0})
                          - 56'({r_f2, 18'd0}) + (56'd4 << 48);
                2'd2: num = 56'({r_f2, 16'd0}) + 56'({r_f2, 17'd0}) + 56'({r_f, 32'd0})
                          + 56'({r_f, 33'd0}) + (56'd1 << 48) - 56'(r_f3)
                          - 56'({r_f3, 1'b0});
                default: num = 56'(r_f3);
            endcase
        end else begin
            case (r_r)
                2'd0:    num = 56'(r_g2);
                2'd1:    num = (56'd1 << 32) + 56'({r_f, 17'd0}) - 56'({r_f2, 1'b0});
                default: num = 56'(r_f2);
            endcase
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_BZ_A: begin
                mul_a = $signed(MUL_W'(r_s));
                mul_b = $signed(MUL_W'(w_rd));
            end
            S_BZ_B: begin
                mul_a = $signed(MUL_W'(r_t));
                mul_b = (r_i == '0) ? '0 : $signed(MUL_W'(w_rd));
            end
            S_SP_F2: begin
                mul_a = $signed(MUL_W'(r_f));
                mul_b = $signed(MUL_W'(r_f));
            end
            S_SP_F3: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = $signed(MUL_W'(r_f));
            end
            S_SP_G2: begin
                mul_a = $signed(MUL_W'(r_g));
                mul_b = $signed(MUL_W'(r_g));
            end
            S_SP_G3: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = $signed(MUL_W'(r_g));
            end
            S_SP_DIV1: begin
                mul_a = $signed(MUL_W'(num_rnd[50:19]));
                mul_b = $signed(RECIP3);
            end
            S_AC_MUL: begin
                mul_a = $signed(MUL_W'(w_rd));
                mul_b = MUL_W'($signed(c_rd));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fin_x[c] = r_acc[c] + ACC_W'(64'sd536870912);
            fin_q[c] = fin_x[c][63:30];
            if (fin_q[c] > 34'sd2147483647) begin
                fin[c] = 32'sh7FFFFFFF;
            end else if (fin_q[c] < -34'sd2147483648) begin
                fin[c] = 32'sh80000000;
            end else begin
                fin[c] = fin_q[c][31:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && (t_mode'(i_mode) == MODE_EVAL) && (r_count != '0)) begin
                    if (r_kind == KIND_CUBIC || r_kind == KIND_QUAD) begin
                        n_state = S_SP_F2;
                    end else if (r_count == CNT_W'(1)) begin
                        n_state = S_AC_CHK;
                    end else begin
                        n_state = S_BZ_A;
                    end
                end
            end
            S_BZ_A:  n_state = S_BZ_B;
            S_BZ_B:  n_state = S_BZ_C;
            S_BZ_C: begin
                if (r_i == '0 && {1'b0, r_lvl} == r_count - CNT_W'(1)) begin
                    n_state = S_AC_CHK;
                end else begin
                    n_state = S_BZ_A;
                end
            end
            S_SP_F2: n_state = S_SP_F3;
            S_SP_F3: n_state = S_SP_G2;
            S_SP_G2: n_state = S_SP_G3;
            S_SP_G3: n_state = S_SP_DIV1;
            S_SP_DIV1: begin
                if (r_cubic) begin
                    n_state = S_SP_DIV2;
                end else if (r_r == deg) begin
                    n_state = S_AC_CHK;
                end
            end
            S_SP_DIV2: n_state = (r_r == deg) ? S_AC_CHK : S_SP_DIV1;
            S_AC_CHK: begin
                if (idx_ok) begin
                    n_state = S_AC_MUL;
                end else if (k_last) begin
                    n_state = S_FIN;
                end
            end
            S_AC_MUL: n_state = S_AC_ADD;
            S_AC_ADD: begin
                if (r_j == 2'd2) begin
                    n_state = k_last ? S_FIN : S_AC_CHK;
                end else begin
                    n_state = S_AC_MUL;
                end
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_BEZIER;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kind <= t_kind'(i_cfg_wdata);
            end
            if (r_state == S_IDLE && start) begin
                o_curve_x    <= '0;
                o_curve_y    <= '0;
                o_curve_z    <= '0;
                unique case (t_mode'(i_mode))
                    MODE_CLEAR: begin
                        r_count       <= '0;
                        o_point_count <= '0;
                        o_store_full  <= 1'b0;
                        o_done        <= 1'b1;
                    end
                    MODE_APPEND: begin
                        if (r_count < CNT_W'(MAX_POINTS)) begin
                            r_cx[r_count[IDX_W-1:0]] <= i_point_x;
                            r_cy[r_count[IDX_W-1:0]] <= i_point_y;
                            r_cz[r_count[IDX_W-1:0]] <= i_point_z;
                            r_count       <= r_count + CNT_W'(1);
                            o_point_count <= r_count + CNT_W'(1);
                            o_store_full  <= 1'b0;
                        end else begin
                            o_point_count <= r_count;
                            o_store_full  <= 1'b1;
                        end
                        o_done <= 1'b1;
                    end
                    MODE_EVAL: begin
                        o_point_count <= r_count;
                        o_store_full  <= 1'b0;
                        o_done        <= (r_count == '0);
                    end
                    default: begin
                        o_point_count <= r_count;
                        o_store_full  <= 1'b0;
                        o_done        <= 1'b1;
                    end
                endcase
            end else if (r_state == S_FIN) begin
                o_curve_x     <= fin[0];
                o_curve_y     <= fin[1];
                o_curve_z     <= fin[2];
                o_point_count <= r_count;
                o_store_full  <= 1'b0;
                o_done        <= 1'b1;
            end else begin
                o_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            S_IDLE: begin
                r_t     <= (i_curve_param > 21'(ONE_Q16)) ? ONE_Q16 : i_curve_param[16:0];
                r_s     <= ONE_Q16 - ((i_curve_param > 21'(ONE_Q16)) ? ONE_Q16
                                                                      : i_curve_param[16:0]);
                r_f     <= i_curve_param[15:0];
                r_g     <= ONE_Q16 - {1'b0, i_curve_param[15:0]};
                r_cubic <= (r_kind == KIND_CUBIC);
                r_r     <= '0;
                r_lvl   <= IDX_W'(1);
                r_i     <= IDX_W'(1);
                r_k     <= '0;
                r_j     <= '0;
                for (int e = 0; e < 3; e++) begin
                    r_acc[e] <= '0;
                end
                for (int e = 0; e < MAX_POINTS; e++) begin
                    r_w[e] <= (e == 0) ? ONE_Q30 : '0;
                end
                if (r_kind == KIND_CUBIC) begin
                    r_n    <= CNT_W'(4);
                    r_base <= $signed({2'b00, i_curve_param[20:16]}) - 7'sd3;
                end else if (r_kind == KIND_QUAD) begin
                    r_n    <= CNT_W'(3);
                    r_base <= $signed({2'b00, i_curve_param[20:16]}) - 7'sd2;
                end else begin
                    r_n    <= r_count;
                    r_base <= '0;
                end
            end
            S_BZ_B: begin
                r_sum <= r_prod[47:0];
            end
            S_BZ_C: begin
                r_w[r_i] <= bz_new[46:16];
                if (r_i == '0) begin
                    r_lvl <= r_lvl + IDX_W'(1);
                    r_i   <= r_lvl + IDX_W'(1);
                end else begin
                    r_i <= r_i - IDX_W'(1);
                end
            end
            S_SP_F3: r_f2 <= r_prod[31:0];
            S_SP_G2: r_f3 <= r_prod[47:0];
            S_SP_G3: r_g2 <= r_prod[32:0];
            S_SP_DIV1: begin
                if (!r_cubic) begin
                    r_w[IDX_W'(r_r)] <= num_rnd[33:3];
                    r_r              <= r_r + 2'd1;
                end
            end
            S_SP_DIV2: begin
                r_w[IDX_W'(r_r)] <= r_prod[63:33];
                r_r              <= r_r + 2'd1;
            end
            S_AC_CHK: begin
                r_idx <= idx[IDX_W-1:0];
                r_j   <= '0;
                if (!idx_ok && !k_last) begin
                    r_k <= r_k + IDX_W'(1);
                end
            end
            S_AC_ADD: begin
                r_acc[r_j] <= r_acc[r_j] + r_prod[ACC_W-1:0];
                if (r_j == 2'd2) begin
                    r_j <= '0;
                    if (!k_last) begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end else begin
                    r_j <= r_j + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bezier / uniform b-spline curve evaluator:
// a queue-fed driver issues clear, append, evaluate and no-op commands, a monitor
// predicts each result from its own copy of the point store and curve kind
// and compares every o_done result field by field, in order
// ----------------------------------------------------------------------------
module testbench;
    import bbce_pkg::*;

    localparam int LIMIT = 3000000;

    typedef struct {
        t_mode             mode;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [20:0]        param;
    } t_cmd;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [CNT_W-1:0]   cnt;
        logic               full;
    } t_curve_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_mode = MODE_NONE;
    logic signed [31:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic [20:0] i_curve_param = '0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_wdata = '0;
    logic o_done;
    logic signed [31:0] o_curve_x, o_curve_y, o_curve_z;
    logic [CNT_W-1:0] o_point_count;
    logic o_store_full;

    bezier_bspline_curve_eval u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_point_x(i_point_x), .i_point_y(i_point_y),
        .i_point_z(i_point_z), .i_curve_param(i_curve_param),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_done(o_done),
        .o_curve_x(o_curve_x), .o_curve_y(o_curve_y), .o_curve_z(o_curve_z),
        .o_point_count(o_point_count), .o_store_full(o_store_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cmd       pending_cmds[$];
    t_curve_res expected_curve[$];
    int         idle_pct = 19;
    logic       took = 1'b0;
    int         cycles = 0, mismatches = 0, n_results = 0;
    int         n_evals = 0, n_full = 0;

    // predictor state
    t_kind       kind_q = KIND_BEZIER;
    longint      pts_x[MAX_POINTS], pts_y[MAX_POINTS], pts_z[MAX_POINTS];
    int          pts_n = 0;

    function automatic longint round_sat(longint acc);
        longint q;
        q = (acc + 64'sd536870912) >>> 30;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function automatic t_curve_res predict_curve(t_cmd c);
        t_curve_res r;
        longint unsigned w[MAX_POINTS];
        longint unsigned t, s, a, b;
        longint num[4];
        longint sw[4];
        longint ax, ay, az, f, g, span, idx, bigf, den;
        int deg;
        ax = 0; ay = 0; az = 0;
        r.full = 1'b0;
        case (c.mode)
            MODE_CLEAR: pts_n = 0;
            MODE_APPEND: begin
                if (pts_n < MAX_POINTS) begin
                    pts_x[pts_n] = c.px; pts_y[pts_n] = c.py; pts_z[pts_n] = c.pz;
                    pts_n++;
                end else begin
                    r.full = 1'b1;
                end
            end
            MODE_EVAL: begin
                if (pts_n > 0 && (kind_q == KIND_CUBIC || kind_q == KIND_QUAD)) begin
                    bigf = 65536;
                    f = c.param[15:0];
                    g = bigf - f;
                    span = c.param[20:16];
                    if (kind_q == KIND_CUBIC) begin
                        den = 64'd6 << 18;
                        num[0] = g * g * g;
                        num[1] = 3*f*f*f - 6*f*f*bigf + 4*bigf*bigf*bigf;
                        num[2] = -3*f*f*f + 3*f*f*bigf + 3*f*bigf*bigf + bigf*bigf*bigf;
                        num[3] = f * f * f;
                        for (int k = 0; k < 4; k++) sw[k] = (num[k] + den / 2) / den;
                        deg = 3;
                    end else begin
                        num[0] = g * g;
                        num[1] = -2*f*f + 2*f*bigf + bigf*bigf;
                        num[2] = f * f;
                        for (int k = 0; k < 3; k++) sw[k] = (num[k] + 4) >>> 3;
                        deg = 2;
                    end
                    for (int k = 0; k <= deg; k++) begin
                        idx = span - deg + k;
                        if (idx >= 0 && idx < pts_n) begin
                            ax += sw[k] * pts_x[idx];
                            ay += sw[k] * pts_y[idx];
                            az += sw[k] * pts_z[idx];
                        end
                    end
                end else if (pts_n > 0) begin
                    t = (c.param > 65536) ? 65536 : c.param;
                    s = 65536 - t;
                    for (int k = 0; k < MAX_POINTS; k++) w[k] = 0;
                    w[0] = 64'd1 << 30;
                    for (int lvl = 1; lvl < pts_n; lvl++) begin
                        for (int i = lvl; i >= 0; i--) begin
                            a = w[i];
                            b = (i > 0) ? w[i-1] : 0;
                            w[i] = (s * a + t * b + 32768) >> 16;
                        end
                    end
                    for (int i = 0; i < pts_n; i++) begin
                        ax += longint'(w[i]) * pts_x[i];
                        ay += longint'(w[i]) * pts_y[i];
                        az += longint'(w[i]) * pts_z[i];
                    end
                end
            end
            default: ;
        endcase
        r.cx = 32'(round_sat(ax));
        r.cy = 32'(round_sat(ay));
        r.cz = 32'(round_sat(az));
        r.cnt = CNT_W'(pts_n);
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                t_cmd c;
                c = pending_cmds.pop_front();
                start <= 1'b1;
                i_mode <= c.mode;
                i_point_x <= c.px;
                i_point_y <= c.py;
                i_point_z <= c.pz;
                i_curve_param <= c.param;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cmd c;
        t_curve_res e;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("bezier_bspline_curve_eval verification failed");
            $finish;
        end else if (i_rst_n) begin
            took <= start && !busy;
            if (i_cfg_we) kind_q = t_kind'(i_cfg_wdata);
            if (start && !busy) begin
                c.mode = t_mode'(i_mode);
                c.px = i_point_x; c.py = i_point_y; c.pz = i_point_z;
                c.param = i_curve_param;
                if (c.mode == MODE_EVAL) n_evals++;
                expected_curve.push_back(predict_curve(c));
            end
            if (o_done) begin
                n_results++;
                if (expected_curve.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result with no transaction pending");
                end else begin
                    e = expected_curve.pop_front();
                    if (e.full) n_full++;
                    if (o_curve_x !== e.cx || o_curve_y !== e.cy || o_curve_z !== e.cz ||
                        o_point_count !== e.cnt || o_store_full !== e.full) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %h %h cnt %0d full %0d, got %h %h %h cnt %0d full %0d",
                                     e.cx, e.cy, e.cz, e.cnt, e.full, o_curve_x, o_curve_y,
                                     o_curve_z, o_point_count, o_store_full);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom_range(0, 32'h000fffff) - 32'sh00080000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cmd(t_mode m, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [20:0] p);
        t_cmd c;
        c.mode = m; c.px = x; c.py = y; c.pz = z; c.param = p;
        pending_cmds.push_back(c);
    endtask

    task automatic drain_and_set_kind(t_kind k);
        do begin
            @(posedge i_clk);
        end while (pending_cmds.size() != 0 || expected_curve.size() != 0 || start || busy);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= k;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_param(t_kind k, int n, output logic [20:0] p);
        case ($urandom_range(0, 9))
            0: p = 21'd1048576;
            1: p = 21'($urandom);
            2: p = 21'd0;
            default: begin
                if (k == KIND_BEZIER || k == KIND_SPARE) p = 21'($urandom_range(0, 65536));
                else p = {5'($urandom_range(0, n + 3)), 16'($urandom)};
            end
        endcase
    endtask

    task automatic random_phase(t_kind k, int items);
        int n, done_items;
        logic [20:0] p;
        done_items = 0;
        while (done_items < items) begin
            if ($urandom_range(0, 9) == 0) begin
                add_cmd(t_mode'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                        rand_coord(), 21'($urandom));
                done_items++;
            end else begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 17)
                                                : $urandom_range(0, 8);
                add_cmd(MODE_CLEAR, $urandom, $urandom, $urandom, 21'($urandom));
                for (int i = 0; i < n; i++)
                    add_cmd(MODE_APPEND, rand_coord(), rand_coord(), rand_coord(),
                            21'($urandom));
                for (int i = 0; i < 4; i++) begin
                    random_param(k, n, p);
                    add_cmd(MODE_EVAL, $urandom, $urandom, $urandom, p);
                end
                done_items += n + 5;
            end
        end
    endtask

    initial begin
        t_kind kinds[6];
        kinds = '{KIND_BEZIER, KIND_CUBIC, KIND_QUAD, KIND_SPARE, KIND_CUBIC, KIND_BEZIER};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, single point, extremes, full store, MODE_NONE command
        add_cmd(MODE_EVAL, '0, '0, '0, 21'd32768);
        add_cmd(MODE_NONE, '1, '1, '1, '1);
        add_cmd(MODE_APPEND, 32'h7fffffff, 32'h80000000, 32'h00010000, '0);
        add_cmd(MODE_EVAL, '0, '0, '0, 21'd40000);
        add_cmd(MODE_APPEND, 32'h7fffffff, 32'h80000000, 32'hffff0000, '0);
        add_cmd(MODE_EVAL, '0, '0, '0, 21'd1048576);
        add_cmd(MODE_EVAL, '0, '0, '0, 21'd0);
        add_cmd(MODE_EVAL, '0, '0, '0, 21'd65536);
        add_cmd(MODE_EVAL, '0, '0, '0, 21'h1fffff);
        for (int i = 0; i < 15; i++)
            add_cmd(MODE_APPEND, rand_coord(), rand_coord(), rand_coord(), '0);
        add_cmd(MODE_EVAL, '0, '0, '0, 21'd21845);
        add_cmd(MODE_CLEAR, '0, '0, '0, '0);
        add_cmd(MODE_EVAL, '0, '0, '0, 21'd100);

        foreach (kinds[i]) begin
            drain_and_set_kind(kinds[i]);
            idle_pct = (i == 4) ? 0 : 19;
            random_phase(kinds[i], 100);
        end
        drain_and_set_kind(KIND_BEZIER);

        wait (pending_cmds.size() == 0 && expected_curve.size() == 0 && !start);
        repeat (600) @(posedge i_clk);
        $display("%0d results checked, %0d evaluations, %0d appends refused as full",
                 n_results, n_evals, n_full);
        $display("curve kinds bezier, cubic, quadratic and spare each exercised");
        if (mismatches == 0 && expected_curve.size() == 0) begin
            $display("bezier_bspline_curve_eval verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("bezier_bspline_curve_eval verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/bbce_pkg.sv
src/bezier_bspline_curve_eval.sv
sim/testbench.sv
